### rtl/core/gbte_pkg.sv
// Shared types and codes for the gap buffer text editor.
// Holds the operation and status encodings and the fixed field widths.
// No dependencies.
`default_nettype none

package gbte_pkg;

  // Fixed widths of the beat fields.
  localparam int OP_W     = 2;
  localparam int CHAR_W   = 8;
  localparam int DELTA_W  = 9;
  localparam int RIDX_W   = 7;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 8;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [CHAR_W-1:0]   char_t;

  // Operation codes.
  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_DELETE = 2'd1;
  localparam op_t OP_MOVE   = 2'd2;
  localparam op_t OP_READ   = 2'd3;

  // Status codes.
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_RANGE = 2'd2;
  localparam status_t ST_NODEL = 2'd3;

endpackage

`default_nettype wire

### rtl/core/gap_buffer_text_editor.sv
// Gap buffer text editor: fixed-capacity text store with a movable gap.
// Depends on gbte_pkg for operation and status codes and field widths.
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid/in_ready, in_op, in_char_in,        | input
//          | in_delta, in_read_index                      |
//  out     | out_valid/out_ready, out_status,             | output
//          | out_read_data, out_cursor, out_text_length   |
//
// Insert, delete and rejected operations finish in the accept cycle, with
// the result in the output register on the next edge. A read does its
// synchronous store read on accept, then loads from S_READ when the output
// slot is free. A move shifts its bytes across the gap one at a time on the
// single store read port, waits for the last byte's write, then loads when
// the output slot is free. Reset clears the gap to cover the whole store;
// the store is not cleared. A held result stalls the next beat until taken.
`default_nettype none

module gap_buffer_text_editor
  import gbte_pkg::*;
#(
  parameter int BUFFER_DEPTH = 128
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [OP_W-1:0]            in_op,
  input  wire logic [CHAR_W-1:0]          in_char_in,
  input  wire logic signed [DELTA_W-1:0]  in_delta,
  input  wire logic [RIDX_W-1:0]          in_read_index,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [STATUS_W-1:0]             out_status,
  output logic [CHAR_W-1:0]               out_read_data,
  output logic [COUNT_W-1:0]              out_cursor,
  output logic [COUNT_W-1:0]              out_text_length
);

  // Address, pointer and arithmetic widths.
  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int PW = $clog2(BUFFER_DEPTH + 1);
  localparam int LW = PW + 1;
  localparam int SW = ((PW > DELTA_W) ? PW : DELTA_W) + 2;

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOVE = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [PW-1:0] gb_r, gb_nxt;
  logic [PW-1:0] gf_r, gf_nxt;
  logic [PW-1:0] cnt_r, cnt_nxt;
  logic          dir_left_r, dir_left_nxt;
  logic          wr_pend_r, wr_pend_nxt;
  logic [AW-1:0] wr_addr_r, wr_addr_nxt;
  char_t         rd_data_r;

  logic          out_valid_r;
  status_t       out_status_r;
  char_t         out_read_data_r;
  logic [COUNT_W-1:0] out_cursor_r;
  logic [COUNT_W-1:0] out_text_length_r;

  // Text store.
  char_t         text_mem [BUFFER_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  char_t         mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  logic          slot_free;
  logic          in_fire;
  logic          load_out;
  status_t       status_nxt;
  char_t         rdata_nxt;

  logic [PW-1:0]        gb_inc, gb_dec, gf_inc, gf_dec, cnt_dec;
  logic [SW-1:0]        len_u;
  logic signed [SW-1:0] gb_s;
  logic signed [SW-1:0] target_s;
  logic                 move_bad;
  logic                 move_left;
  logic [PW-1:0]        move_n;
  logic [SW-1:0]        ridx_u;
  logic [SW-1:0]        phys_u;
  logic                 rd_ok;
  logic [LW-1:0]        len_nxt;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign in_fire   = in_valid && in_ready;

  assign gb_inc  = gb_r + 1'b1;
  assign gb_dec  = gb_r - 1'b1;
  assign gf_inc  = gf_r + 1'b1;
  assign gf_dec  = gf_r - 1'b1;
  assign cnt_dec = cnt_r - 1'b1;

  // Text length and move target checks.
  assign len_u    = SW'(gb_r) + SW'(BUFFER_DEPTH) - SW'(gf_r);
  assign gb_s     = $signed(SW'(gb_r));
  assign target_s = gb_s + SW'(in_delta);
  assign move_bad = (target_s < 0) || (target_s > $signed(len_u));
  assign move_left = (target_s < gb_s);
  assign move_n   = move_left ? PW'(gb_s - target_s) : PW'(target_s - gb_s);

  // Logical to physical index for reads.
  assign ridx_u = SW'(in_read_index);
  assign rd_ok  = (ridx_u < len_u);
  assign phys_u = (ridx_u < SW'(gb_r)) ? ridx_u : (SW'(gf_r) + ridx_u - SW'(gb_r));

  // Sequencer and store access control.
  always_comb begin
    state_nxt    = state_r;
    gb_nxt       = gb_r;
    gf_nxt       = gf_r;
    cnt_nxt      = cnt_r;
    dir_left_nxt = dir_left_r;
    wr_pend_nxt  = 1'b0;
    wr_addr_nxt  = wr_addr_r;
    mem_we       = wr_pend_r;
    mem_waddr    = wr_addr_r;
    mem_wdata    = rd_data_r;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    load_out     = 1'b0;
    status_nxt   = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_INSERT: begin
              load_out = 1'b1;
              if (gb_r >= gf_r) begin
                status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = gb_r[AW-1:0];
                mem_wdata = in_char_in;
                gb_nxt    = gb_inc;
              end
            end
            OP_DELETE: begin
              load_out = 1'b1;
              if (gb_r != '0) begin
                gb_nxt = gb_dec;
              end else begin
                status_nxt = ST_NODEL;
              end
            end
            OP_MOVE: begin
              if (move_bad) begin
                load_out   = 1'b1;
                status_nxt = ST_RANGE;
              end else if (move_n == '0) begin
                load_out = 1'b1;
              end else begin
                state_nxt    = S_MOVE;
                cnt_nxt      = move_n;
                dir_left_nxt = move_left;
              end
            end
            OP_READ: begin
              if (!rd_ok) begin
                load_out   = 1'b1;
                status_nxt = ST_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = phys_u[AW-1:0];
                state_nxt = S_READ;
              end
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      S_MOVE: begin
        // One byte crosses the gap per cycle; its write lands in the next cycle.
        if (cnt_r != '0) begin
          mem_re      = 1'b1;
          wr_pend_nxt = 1'b1;
          cnt_nxt     = cnt_dec;
          if (dir_left_r) begin
            mem_raddr   = gb_dec[AW-1:0];
            wr_addr_nxt = gf_dec[AW-1:0];
            gb_nxt      = gb_dec;
            gf_nxt      = gf_dec;
          end else begin
            mem_raddr   = gf_r[AW-1:0];
            wr_addr_nxt = gb_r[AW-1:0];
            gb_nxt      = gb_inc;
            gf_nxt      = gf_inc;
          end
        end else if (!wr_pend_r && slot_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        if (slot_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign rdata_nxt = (state_r == S_READ) ? rd_data_r : '0;
  assign len_nxt   = LW'(gb_nxt) + LW'(BUFFER_DEPTH) - LW'(gf_nxt);

  // Text store with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      text_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= text_mem[mem_raddr];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      gb_r       <= '0;
      gf_r       <= PW'(BUFFER_DEPTH);
      cnt_r      <= '0;
      dir_left_r <= 1'b0;
      wr_pend_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      gb_r       <= gb_nxt;
      gf_r       <= gf_nxt;
      cnt_r      <= cnt_nxt;
      dir_left_r <= dir_left_nxt;
      wr_pend_r  <= wr_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= wr_addr_nxt;
  end

  // Output register for the result beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r      <= status_nxt;
      out_read_data_r   <= rdata_nxt;
      out_cursor_r      <= COUNT_W'(gb_nxt);
      out_text_length_r <= COUNT_W'(len_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_data   = out_read_data_r;
  assign out_cursor      = out_cursor_r;
  assign out_text_length = out_text_length_r;

  // The gap never has negative size.
  a_gap_order: assert property (@(posedge clk) disable iff (!rst_n)
    gb_r <= gf_r)
    else $error("gap start passed gap end");

  // The gap end never passes the end of the store.
  a_gap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    gf_r <= PW'(BUFFER_DEPTH))
    else $error("gap end beyond store");

  // A shift step keeps the gap size.
  a_move_keeps_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE) |=> ((gf_r - gb_r) == ($past(gf_r) - $past(gb_r))))
    else $error("cursor move changed gap size");

  // A pending shift write only exists while a move is in progress.
  a_write_in_move: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> (state_r == S_MOVE))
    else $error("shift write outside a move");

endmodule

`default_nettype wire

### test/tb_gap_buffer_text_editor.sv
// Self-checking testbench for the gap buffer text editor.
// Drives edit beats through a directed table and then random editing bursts, and compares
// every result beat with a local gap buffer predictor or a checked row's fixed result. Uses gbte_pkg.
`default_nettype none

module tb_gap_buffer_text_editor;
  import gbte_pkg::*;

  localparam int DEPTH       = 128;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_STALL  = 400;
  localparam int PHASE_ITEMS = 370;
  localparam int DRAIN_WAIT  = 200;

  typedef struct packed {
    op_t                        op;
    char_t                      ch;
    logic signed [DELTA_W-1:0]  delta;
    logic [RIDX_W-1:0]          ridx;
  } edit_req_t;

  typedef struct packed {
    status_t                    status;
    char_t                      rdata;
    logic [COUNT_W-1:0]         cursor;
    logic [COUNT_W-1:0]         length;
  } edit_rsp_t;

  typedef struct packed {
    edit_req_t req;
    logic      typed;
    edit_rsp_t rsp;
  } dir_row_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [OP_W-1:0]            in_op;
  logic [CHAR_W-1:0]          in_char_in;
  logic signed [DELTA_W-1:0]  in_delta;
  logic [RIDX_W-1:0]          in_read_index;
  logic                       out_valid;
  logic                       out_ready;
  logic [STATUS_W-1:0]        out_status;
  logic [CHAR_W-1:0]          out_read_data;
  logic [COUNT_W-1:0]         out_cursor;
  logic [COUNT_W-1:0]         out_text_length;

  // Predictor state: text bytes and the gap bounds.
  char_t     text_mem [DEPTH];
  int        gap_lo;
  int        gap_hi;

  edit_rsp_t pending_results [$];
  dir_row_t  dir_rows [$];
  int        fail_count;
  int        items_sent;
  int        send_idle_pct;
  int        recv_idle_pct;
  bit        long_stall_req;

  gap_buffer_text_editor #(
    .BUFFER_DEPTH(DEPTH)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_char_in      (in_char_in),
    .in_delta        (in_delta),
    .in_read_index   (in_read_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_read_data   (out_read_data),
    .out_cursor      (out_cursor),
    .out_text_length (out_text_length)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int text_length();
    return gap_lo + (DEPTH - gap_hi);
  endfunction

  // Applies one edit to the predictor state and returns the expected result.
  function automatic edit_rsp_t apply_edit(input edit_req_t req);
    edit_rsp_t rsp;
    int        len;
    int        dl;
    int        target;
    int        n;
    rsp.status = ST_OK;
    rsp.rdata  = '0;
    len        = text_length();
    dl         = $signed(req.delta);
    case (req.op)
      OP_INSERT: begin
        if (gap_lo >= gap_hi) begin
          rsp.status = ST_FULL;
        end else begin
          text_mem[gap_lo] = req.ch;
          gap_lo++;
        end
      end
      OP_DELETE: begin
        if (gap_lo > 0) begin
          gap_lo--;
        end else begin
          rsp.status = ST_NODEL;
        end
      end
      OP_MOVE: begin
        target = gap_lo + dl;
        if (target < 0 || target > len) begin
          rsp.status = ST_RANGE;
        end else if (target < gap_lo) begin
          // Bytes left of the cursor move to the top of the gap, highest first.
          n = gap_lo - target;
          for (int i = n - 1; i >= 0; i--) begin
            text_mem[gap_hi - n + i] = text_mem[target + i];
          end
          gap_lo = target;
          gap_hi = gap_hi - n;
        end else if (target > gap_lo) begin
          // Bytes right of the gap move down to the cursor, lowest first.
          n = target - gap_lo;
          for (int i = 0; i < n; i++) begin
            text_mem[gap_lo + i] = text_mem[gap_hi + i];
          end
          gap_lo = gap_lo + n;
          gap_hi = gap_hi + n;
        end
      end
      default: begin
        if (int'(req.ridx) >= len) begin
          rsp.status = ST_RANGE;
        end else if (int'(req.ridx) < gap_lo) begin
          rsp.rdata = text_mem[req.ridx];
        end else begin
          rsp.rdata = text_mem[gap_hi + int'(req.ridx) - gap_lo];
        end
      end
    endcase
    rsp.cursor = gap_lo[COUNT_W-1:0];
    rsp.length = COUNT_W'(text_length());
    return rsp;
  endfunction

  // Picks a random edit. Sane edits mostly target valid positions; wild ones do not.
  function automatic edit_req_t pick_edit(input bit wild);
    edit_req_t req;
    int        len;
    int        pick;
    len       = text_length();
    req.op    = op_t'($urandom_range(0, 3));
    req.ch    = char_t'($urandom);
    req.delta = DELTA_W'($urandom_range(0, 256) - 128);
    req.ridx  = RIDX_W'($urandom);
    if (!wild) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        req.op = OP_INSERT;
      end else if (pick < 50) begin
        req.op = OP_DELETE;
      end else if (pick < 75) begin
        req.op = OP_MOVE;
      end else begin
        req.op = OP_READ;
      end
      if (req.op == OP_MOVE && $urandom_range(0, 4) != 0) begin
        req.delta = DELTA_W'($urandom_range(0, len) - gap_lo);
      end
      if (req.op == OP_READ && len > 0 && $urandom_range(0, 6) != 0) begin
        req.ridx = RIDX_W'($urandom_range(0, len - 1));
      end
    end
    return req;
  endfunction

  function automatic edit_req_t make_req(input op_t op, input int ch, input int dl,
                                         input int ri);
    edit_req_t req;
    req.op    = op;
    req.ch    = char_t'(ch);
    req.delta = DELTA_W'(dl);
    req.ridx  = RIDX_W'(ri);
    return req;
  endfunction

  function automatic void add_row(input op_t op, input int ch, input int dl, input int ri);
    dir_row_t row;
    row.req   = make_req(op, ch, dl, ri);
    row.typed = 1'b0;
    row.rsp   = '0;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_checked_row(input op_t op, input int ch, input int dl,
                                          input int ri, input status_t st, input int rd,
                                          input int cur, input int len);
    dir_row_t row;
    row.req        = make_req(op, ch, dl, ri);
    row.typed      = 1'b1;
    row.rsp.status = st;
    row.rsp.rdata  = char_t'(rd);
    row.rsp.cursor = COUNT_W'(cur);
    row.rsp.length = COUNT_W'(len);
    dir_rows.push_back(row);
  endfunction

  // Offers one beat after a random idle gap and records its expected result.
  task automatic send_edit(input edit_req_t req, input logic typed, input edit_rsp_t fixed);
    edit_rsp_t rsp;
    int        gap;
    gap = 0;
    while (gap < 50 && $urandom_range(0, 99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= req.op;
    in_char_in    <= req.ch;
    in_delta      <= req.delta;
    in_read_index <= req.ridx;
    do begin
      @(posedge clk);
    end while (!in_ready);
    rsp = apply_edit(req);
    pending_results.push_back(typed ? fixed : rsp);
    items_sent++;
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        stall_left     = LONG_STALL;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Result checker: each result beat against the oldest expectation.
  always @(posedge clk) begin
    edit_rsp_t got;
    edit_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      got.status = out_status;
      got.rdata  = out_read_data;
      got.cursor = out_cursor;
      got.length = out_text_length;
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected result: status %0d data %02h cursor %0d length %0d",
                   got.status, got.rdata, got.cursor, got.length);
        end
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.rdata !== want.rdata ||
            got.cursor !== want.cursor || got.length !== want.length) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch: expected status %0d data %02h cursor %0d length %0d",
                     want.status, want.rdata, want.cursor, want.length);
            $display("          actual   status %0d data %02h cursor %0d length %0d",
                     got.status, got.rdata, got.cursor, got.length);
          end
        end
      end
    end
  end

  // Watchdog.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    edit_req_t req;
    int        burst;
    int        count;
    bit        stall_done;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_op          = OP_INSERT;
    in_char_in     = '0;
    in_delta       = '0;
    in_read_index  = '0;
    fail_count     = 0;
    items_sent     = 0;
    send_idle_pct  = 17;
    recv_idle_pct  = 77;
    long_stall_req = 1'b0;
    stall_done     = 1'b0;
    gap_lo         = 0;
    gap_hi         = DEPTH;
    for (int i = 0; i < DEPTH; i++) begin
      text_mem[i] = '0;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed edits: empty-buffer errors, field extremes, moves both ways.
    add_checked_row(OP_DELETE, 8'hFF,    0,   0, ST_NODEL, 0, 0, 0);
    add_checked_row(OP_READ,   8'h00,    0,   0, ST_RANGE, 0, 0, 0);
    add_checked_row(OP_MOVE,   8'h00,    1,   0, ST_RANGE, 0, 0, 0);
    add_checked_row(OP_MOVE,   8'h00,    0,   0, ST_OK,    0, 0, 0);
    add_checked_row(OP_MOVE,   8'hFF, -128, 127, ST_RANGE, 0, 0, 0);
    add_checked_row(OP_MOVE,   8'h00,  128,   0, ST_RANGE, 0, 0, 0);
    add_checked_row(OP_READ,   8'hFF,   -1, 127, ST_RANGE, 0, 0, 0);
    add_checked_row(OP_INSERT, 8'h00,    0,   0, ST_OK,    0, 1, 1);
    add_checked_row(OP_INSERT, 8'hFF,   -1, 127, ST_OK,    0, 2, 2);
    add_checked_row(OP_INSERT, 8'hA5,  128,   0, ST_OK,    0, 3, 3);
    add_checked_row(OP_READ,   8'h00,    0,   0, ST_OK,    8'h00, 3, 3);
    add_checked_row(OP_READ,   8'h00,    0,   1, ST_OK,    8'hFF, 3, 3);
    add_checked_row(OP_READ,   8'h00,    0,   3, ST_RANGE, 0, 3, 3);
    add_row(OP_MOVE,   8'h00,   -2,   0);
    add_row(OP_READ,   8'h00,    0,   2);
    add_row(OP_INSERT, 8'h5A,    0,   0);
    add_row(OP_MOVE,   8'h00,    2,   0);
    add_row(OP_MOVE,   8'h00,    1,   0);
    add_row(OP_MOVE,   8'h00,   -5,   0);
    add_row(OP_MOVE,   8'h00,   -4,   0);
    add_row(OP_DELETE, 8'h00,    0,   0);
    add_row(OP_READ,   8'h00,    0,   3);
    add_row(OP_MOVE,   8'h00,    4,   0);
    add_row(OP_DELETE, 8'h00,    0,   0);
    add_row(OP_READ,   8'h00,    0,   0);
    foreach (dir_rows[i]) begin
      send_edit(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
    end

    // Random editing in three idling phases.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 77 : 0;
      recv_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 17 : 0;
      count = items_sent;
      while (items_sent - count < PHASE_ITEMS) begin
        // Long receiver hold-off while the sender keeps offering beats.
        if (phase == 2 && !stall_done && items_sent - count >= 40) begin
          long_stall_req = 1'b1;
          stall_done     = 1'b1;
        end
        burst = $urandom_range(0, 9);
        if (burst <= 5) begin
          repeat ($urandom_range(8, 24)) send_edit(pick_edit(1'b0), 1'b0, '0);
        end else if (burst == 6) begin
          // Type until the buffer is full, then a few rejected inserts.
          while (gap_lo < gap_hi) begin
            req    = pick_edit(1'b1);
            req.op = OP_INSERT;
            send_edit(req, 1'b0, '0);
          end
          repeat ($urandom_range(1, 3)) begin
            req    = pick_edit(1'b1);
            req.op = OP_INSERT;
            send_edit(req, 1'b0, '0);
          end
        end else if (burst == 7) begin
          // Jump to the end of the text and erase all of it, one past empty.
          req       = pick_edit(1'b1);
          req.op    = OP_MOVE;
          req.delta = DELTA_W'(text_length() - gap_lo);
          send_edit(req, 1'b0, '0);
          while (gap_lo > 0) begin
            req    = pick_edit(1'b1);
            req.op = OP_DELETE;
            send_edit(req, 1'b0, '0);
          end
          req    = pick_edit(1'b1);
          req.op = OP_DELETE;
          send_edit(req, 1'b0, '0);
        end else begin
          repeat ($urandom_range(4, 10)) send_edit(pick_edit(1'b1), 1'b0, '0);
        end
      end
    end
    in_valid <= 1'b0;

    // Let every outstanding result arrive, then watch for stray beats.
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
